@@ rtl/upfc_pkg.sv @@
package upfc_pkg;

   // Field and coefficient formats: Q16.16 values, Q8.24 coefficients
   localparam int FIELD_W = 32;
   localparam int FRAC_W  = 24;
   localparam int PROD_W  = 2 * FIELD_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int RND_W   = SUM_W - FRAC_W;
   localparam int ACC_W   = RND_W + 1;

   localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
   localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
   localparam logic signed [SUM_W-1:0]   SUM_HALF  = SUM_W'(1) <<< (FRAC_W - 1);

   // Flux store layout: six banks (two fields by three components) of layer cells
   localparam int LAYER_CELLS     = 4096;
   localparam int CELL_W          = $clog2(LAYER_CELLS);
   localparam int GROUP_W         = 3;
   localparam int GROUPS_PER_BANK = 3;
   localparam int STORE_DEPTH     = 2 * GROUPS_PER_BANK * LAYER_CELLS;
   localparam int ADDR_W          = GROUP_W + CELL_W;

   // Codes
   localparam logic       KIND_PRE    = 1'b0;
   localparam logic       KIND_POST   = 1'b1;
   localparam logic [1:0] COMP_UNUSED = 2'd3;

   typedef struct packed {
      logic                      kind;
      logic                      field_sel;
      logic [CELL_W-1:0]         cell_req;
      logic [1:0]                component;
      logic signed [FIELD_W-1:0] field_value;
      logic signed [FIELD_W-1:0] coef_main;
      logic signed [FIELD_W-1:0] coef_flux;
   } req_payload_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] new_field_value;
      logic                      saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] value;
      logic                      clip;
   } sat_type;

   // Clip a widened sum to the field range
   function automatic sat_type sat_field(input logic signed [ACC_W-1:0] v);
      sat_type r;
      r.clip  = 1'b0;
      r.value = v[FIELD_W-1:0];
      if (v > ACC_W'(FIELD_MAX)) begin
         r.clip  = 1'b1;
         r.value = FIELD_MAX;
      end else if (v < ACC_W'(FIELD_MIN)) begin
         r.clip  = 1'b1;
         r.value = FIELD_MIN;
      end
      return r;
   endfunction

endpackage

@@ rtl/upfc_ram.sv @@
module upfc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; a read returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/upml_flux_cell_update.sv @@
// Absorbing-layer flux update. Each req beat is one field component of one layer cell;
// its rsp beat, taken from the register behind the clip stage, is the value to write
// back. A pre beat answers the stored flux and stores coef_main*value - coef_flux*flux;
// a post beat stores the value and answers old flux + coef_main*value, both rounded to
// nearest and clipped to 32 bits. A beat with the unused component answers its value
// and touches no flux word. Unless stalled, the pipeline takes one beat per cycle: a
// read of the flux RAM at acceptance, two parallel multipliers, a wide add stage and a
// clip stage that writes the flux back. A beat that names the same flux word as one of
// the three beats ahead of it waits until that word has been written. After reset the
// flux RAM is cleared one word a cycle, all 24576 words, and req_stall is held high
// until the sweep ends.
module upml_flux_cell_update (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  upfc_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output upfc_pkg::rsp_payload_type  rsp_payload
);

   typedef struct packed {
      logic                                kind;
      logic                                touch;
      logic [upfc_pkg::ADDR_W-1:0]         addr;
      logic signed [upfc_pkg::FIELD_W-1:0] val;
      logic signed [upfc_pkg::FIELD_W-1:0] cmain;
      logic signed [upfc_pkg::FIELD_W-1:0] cflux;
   } s1_type;

   typedef struct packed {
      logic                                kind;
      logic                                touch;
      logic [upfc_pkg::ADDR_W-1:0]         addr;
      logic signed [upfc_pkg::FIELD_W-1:0] val;
      logic signed [upfc_pkg::FIELD_W-1:0] old;
      logic signed [upfc_pkg::PROD_W-1:0]  p1;
      logic signed [upfc_pkg::PROD_W-1:0]  p2;
   } s2_type;

   typedef struct packed {
      logic                                kind;
      logic                                touch;
      logic [upfc_pkg::ADDR_W-1:0]         addr;
      logic signed [upfc_pkg::FIELD_W-1:0] val;
      logic signed [upfc_pkg::FIELD_W-1:0] old;
      logic signed [upfc_pkg::RND_W-1:0]   pre_rnd;
      logic signed [upfc_pkg::RND_W-1:0]   post_rnd;
   } s3_type;

   localparam logic [upfc_pkg::ADDR_W-1:0] CLEAR_LAST =
      upfc_pkg::ADDR_W'(upfc_pkg::STORE_DEPTH - 1);

   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   upfc_pkg::rsp_payload_type s4_in, s4_ff;
   logic s1_valid_in, s1_valid_ff;
   logic s2_valid_in, s2_valid_ff;
   logic s3_valid_in, s3_valid_ff;
   logic s4_valid_in, s4_valid_ff;
   logic clear_in, clear_ff;
   logic [upfc_pkg::ADDR_W-1:0] clear_cnt_in, clear_cnt_ff;

   logic adv1, adv2, adv3, adv4;
   logic req_accept, hazard;
   logic req_touch;
   logic [upfc_pkg::GROUP_W-1:0] req_group;
   logic [upfc_pkg::ADDR_W-1:0]  req_addr;
   logic [upfc_pkg::FIELD_W-1:0] ram_rd_data;
   logic                         pipe_wr_en;
   logic signed [upfc_pkg::FIELD_W-1:0] pipe_wr_data;
   logic                         ram_wr_en;
   logic [upfc_pkg::ADDR_W-1:0]  ram_wr_addr;
   logic [upfc_pkg::FIELD_W-1:0] ram_wr_data;
   logic signed [upfc_pkg::SUM_W-1:0] pre_sum, post_sum;
   upfc_pkg::sat_type pre_sat, post_sat;

   // Advance each stage when it is empty or the one after it moves
   assign adv4 = !s4_valid_ff || !rsp_stall;
   assign adv3 = !s3_valid_ff || adv4;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;

   // Map the beat onto its flux word
   always_comb begin
      req_touch = (req_payload.component != upfc_pkg::COMP_UNUSED);
      req_group = {1'b0, req_payload.component}
                + (req_payload.field_sel ? upfc_pkg::GROUP_W'(upfc_pkg::GROUPS_PER_BANK)
                                         : upfc_pkg::GROUP_W'(0));
      req_addr  = {req_group, req_payload.cell_req};
   end

   // Hold a beat whose flux word is still being updated ahead of it
   assign hazard = req_touch && (
                      (s1_valid_ff && s1_ff.touch && (s1_ff.addr == req_addr)) ||
                      (s2_valid_ff && s2_ff.touch && (s2_ff.addr == req_addr)) ||
                      (s3_valid_ff && s3_ff.touch && (s3_ff.addr == req_addr)));

   assign req_stall  = clear_ff || !adv1 || hazard;
   assign req_accept = req_valid && !req_stall;

   // Stage 1: capture the beat while the flux RAM is read
   always_comb begin
      s1_in.kind  = req_payload.kind;
      s1_in.touch = req_touch;
      s1_in.addr  = req_addr;
      s1_in.val   = req_payload.field_value;
      s1_in.cmain = req_payload.coef_main;
      s1_in.cflux = req_payload.coef_flux;
      s1_valid_in = adv1 ? req_accept : s1_valid_ff;
   end

   // Stage 2: both products
   always_comb begin
      s2_in.kind  = s1_ff.kind;
      s2_in.touch = s1_ff.touch;
      s2_in.addr  = s1_ff.addr;
      s2_in.val   = s1_ff.val;
      s2_in.old   = ram_rd_data;
      s2_in.p1    = upfc_pkg::PROD_W'(s1_ff.cmain) * upfc_pkg::PROD_W'(s1_ff.val);
      s2_in.p2    = upfc_pkg::PROD_W'(s1_ff.cflux) * upfc_pkg::PROD_W'($signed(ram_rd_data));
      s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
   end

   // Stage 3: exact sums with the rounding half, then drop the fraction
   always_comb begin
      pre_sum  = upfc_pkg::SUM_W'(s2_ff.p1) - upfc_pkg::SUM_W'(s2_ff.p2)
               + upfc_pkg::SUM_HALF;
      post_sum = upfc_pkg::SUM_W'(s2_ff.p1) + upfc_pkg::SUM_HALF;
      s3_in.kind     = s2_ff.kind;
      s3_in.touch    = s2_ff.touch;
      s3_in.addr     = s2_ff.addr;
      s3_in.val      = s2_ff.val;
      s3_in.old      = s2_ff.old;
      s3_in.pre_rnd  = pre_sum[upfc_pkg::SUM_W-1:upfc_pkg::FRAC_W];
      s3_in.post_rnd = post_sum[upfc_pkg::SUM_W-1:upfc_pkg::FRAC_W];
      s3_valid_in    = adv3 ? s2_valid_ff : s3_valid_ff;
   end

   // Stage 4: clip, pick the answer and write the new flux back
   always_comb begin
      pre_sat  = upfc_pkg::sat_field(upfc_pkg::ACC_W'(s3_ff.pre_rnd));
      post_sat = upfc_pkg::sat_field(upfc_pkg::ACC_W'(s3_ff.old)
                                   + upfc_pkg::ACC_W'(s3_ff.post_rnd));
      s4_in.new_field_value = s3_ff.val;
      s4_in.saturated       = 1'b0;
      pipe_wr_data          = s3_ff.val;
      if (s3_ff.touch) begin
         case (s3_ff.kind)
            upfc_pkg::KIND_PRE: begin
               s4_in.new_field_value = s3_ff.old;
               s4_in.saturated       = pre_sat.clip;
               pipe_wr_data          = pre_sat.value;
            end
            upfc_pkg::KIND_POST: begin
               s4_in.new_field_value = post_sat.value;
               s4_in.saturated       = post_sat.clip;
               pipe_wr_data          = s3_ff.val;
            end
            default: begin
               s4_in.new_field_value = s3_ff.val;
               s4_in.saturated       = 1'b0;
               pipe_wr_data          = s3_ff.val;
            end
         endcase
      end
      pipe_wr_en  = s3_valid_ff && adv4 && s3_ff.touch;
      s4_valid_in = adv4 ? s3_valid_ff : s4_valid_ff;
   end

   // Sweep the flux RAM to zero after reset
   always_comb begin
      clear_in     = clear_ff;
      clear_cnt_in = clear_cnt_ff;
      if (clear_ff) begin
         clear_cnt_in = clear_cnt_ff + upfc_pkg::ADDR_W'(1);
         if (clear_cnt_ff == CLEAR_LAST) begin
            clear_in = 1'b0;
         end
      end
   end

   always_comb begin
      ram_wr_en   = clear_ff || pipe_wr_en;
      ram_wr_addr = clear_ff ? clear_cnt_ff : s3_ff.addr;
      ram_wr_data = clear_ff ? '0 : pipe_wr_data;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         clear_ff     <= clear_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
      if (adv2) begin
         s2_ff <= s2_in;
      end
      if (adv3) begin
         s3_ff <= s3_in;
      end
      if (adv4) begin
         s4_ff <= s4_in;
      end
   end

   upfc_ram #(
      .WIDTH (upfc_pkg::FIELD_W),
      .DEPTH (upfc_pkg::STORE_DEPTH)
   ) u_flux_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept && req_touch),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid   = s4_valid_ff;
   assign rsp_payload = s4_ff;

   // No beat enters while the flux RAM is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !req_accept)
      else $error("beat accepted during flux clear");

   // A held result keeps the flux write of the beat behind it back
   a_no_write_when_held: assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && rsp_stall) |-> !pipe_wr_en)
      else $error("flux written while result held");

   // The clear sweep ends only after the last word
   a_clear_full_sweep: assert property (@(posedge clock) disable iff (reset)
      $fell(clear_ff) |-> ($past(clear_cnt_ff) == CLEAR_LAST))
      else $error("flux clear ended early");

endmodule

@@ verif/upml_flux_cell_update_test.sv @@
module upml_flux_cell_update_test;

   localparam int RANDOM_BEATS = 2000;
   localparam int DRAIN_CYCLES = 16;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   upfc_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   upfc_pkg::rsp_payload_type rsp_payload;

   // Beats waiting to be sent, and answers waiting to arrive
   upfc_pkg::req_payload_type beats_to_send[$];
   upfc_pkg::rsp_payload_type flux_answers_due[$];

   // Our own copy of the flux RAM
   logic signed [upfc_pkg::FIELD_W-1:0] flux_model [0:upfc_pkg::STORE_DEPTH-1];

   int beats_taken    = 0;
   int answers_seen   = 0;
   int mismatch_count = 0;

   upml_flux_cell_update DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Round an exact Q24.40 sum to Q16.16, ties toward plus infinity, then clip
   function automatic upfc_pkg::sat_type round_to_q16(input logic signed [71:0] exact);
      logic signed [71:0] q;
      upfc_pkg::sat_type r;
      q = (exact + 72'sd8388608) >>> 24;
      r.clip  = 1'b0;
      r.value = q[upfc_pkg::FIELD_W-1:0];
      if (q > 72'sd2147483647) begin
         r.clip  = 1'b1;
         r.value = upfc_pkg::FIELD_MAX;
      end else if (q < -72'sd2147483648) begin
         r.clip  = 1'b1;
         r.value = upfc_pkg::FIELD_MIN;
      end
      return r;
   endfunction

   // Work out the answer to one beat and update the flux copy
   function automatic upfc_pkg::rsp_payload_type flux_update_answer(
      input upfc_pkg::req_payload_type b);
      int idx;
      logic signed [upfc_pkg::FIELD_W-1:0] v, cm, cf, old;
      logic signed [71:0] exact;
      upfc_pkg::sat_type s;
      upfc_pkg::rsp_payload_type r;
      v  = b.field_value;
      cm = b.coef_main;
      cf = b.coef_flux;
      if (b.component == upfc_pkg::COMP_UNUSED ||
          int'(b.cell_req) >= upfc_pkg::LAYER_CELLS) begin
         r.new_field_value = v;
         r.saturated       = 1'b0;
      end else begin
         idx = (int'(b.field_sel) * upfc_pkg::GROUPS_PER_BANK + int'(b.component))
               * upfc_pkg::LAYER_CELLS + int'(b.cell_req);
         old = flux_model[idx];
         if (b.kind == upfc_pkg::KIND_PRE) begin
            exact = v * cm - cf * old;
            s = round_to_q16(exact);
            flux_model[idx]   = s.value;
            r.new_field_value = old;
            r.saturated       = s.clip;
         end else begin
            flux_model[idx] = v;
            exact = old * 72'sd16777216 + v * cm;
            s = round_to_q16(exact);
            r.new_field_value = s.value;
            r.saturated       = s.clip;
         end
      end
      return r;
   endfunction

   task automatic queue_beat(input logic kind, input logic sel,
                             input logic [upfc_pkg::CELL_W-1:0] cell_idx,
                             input logic [1:0] comp, input logic [31:0] v,
                             input logic [31:0] cm, input logic [31:0] cf);
      upfc_pkg::req_payload_type b;
      b.kind        = kind;
      b.field_sel   = sel;
      b.cell_req    = cell_idx;
      b.component   = comp;
      b.field_value = v;
      b.coef_main   = cm;
      b.coef_flux   = cf;
      beats_to_send.push_back(b);
   endtask

   // Field value: mostly moderate, sometimes extreme or fully random
   function automatic logic [31:0] pick_field();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom;
         default: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      endcase
   endfunction

   // Coefficient: mostly near one in Q8.24
   function automatic logic [31:0] pick_coef();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom;
         default: return 32'h0100_0000 + $urandom_range(0, 32'h007F_FFFF) - 32'h0040_0000;
      endcase
   endfunction

   // Favour a few cells so that flux words are reused and beats collide
   function automatic logic [upfc_pkg::CELL_W-1:0] pick_cell();
      if ($urandom_range(0, 9) < 7)
         return upfc_pkg::CELL_W'($urandom_range(0, 7));
      else if ($urandom_range(0, 3) == 0)
         return '1;
      else
         return upfc_pkg::CELL_W'($urandom);
   endfunction

   // Send beats from the queue; hold a stalled beat unchanged
   always @(posedge clock) begin : drive_req
      logic idle;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            flux_answers_due.push_back(flux_update_answer(req_payload));
            beats_taken++;
         end
         idle = (beats_taken < 700 || beats_taken >= 1100) && ($urandom_range(0, 99) < 32);
         if (req_valid && req_stall) begin
            // hold
         end else if (beats_to_send.size() > 0 && !idle) begin
            req_payload <= beats_to_send.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Check each answer beat against the oldest one due
   always @(posedge clock) begin : watch_rsp
      upfc_pkg::rsp_payload_type due;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            answers_seen++;
            if (flux_answers_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected answer value=%h saturated=%b",
                           rsp_payload.new_field_value, rsp_payload.saturated);
            end else begin
               due = flux_answers_due.pop_front();
               if (due.new_field_value !== rsp_payload.new_field_value ||
                   due.saturated !== rsp_payload.saturated) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"answer %0d: expected value=%h saturated=%b, ",
                               "got value=%h saturated=%b"},
                              answers_seen, due.new_field_value, due.saturated,
                              rsp_payload.new_field_value, rsp_payload.saturated);
               end
            end
         end
         rsp_stall <= (answers_seen < 500 || answers_seen >= 900) &&
                      ($urandom_range(0, 99) < 32);
      end
   end

   initial begin : run_test
      int n;
      logic sel;
      logic [upfc_pkg::CELL_W-1:0] cell_idx;
      logic [1:0] comp;

      for (int i = 0; i < upfc_pkg::STORE_DEPTH; i++)
         flux_model[i] = '0;

      // Directed: extremes, clipping on store and answer, rounding ties
      queue_beat(upfc_pkg::KIND_PRE,  1'b0, 12'd0, 2'd0,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
      queue_beat(upfc_pkg::KIND_PRE,  1'b0, 12'd0, 2'd0,
                 32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
      queue_beat(upfc_pkg::KIND_POST, 1'b0, 12'd0, 2'd0,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_beat(upfc_pkg::KIND_POST, 1'b0, 12'd0, 2'd0,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
      queue_beat(upfc_pkg::KIND_PRE,  1'b1, 12'd4095, 2'd2,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_beat(upfc_pkg::KIND_PRE,  1'b1, 12'd4095, 2'd2,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      queue_beat(upfc_pkg::KIND_POST, 1'b1, 12'd4095, 2'd2,
                 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
      queue_beat(upfc_pkg::KIND_PRE,  1'b0, 12'd100, 2'd1,
                 32'h0000_0001, 32'h0080_0000, 32'h0000_0000);
      queue_beat(upfc_pkg::KIND_PRE,  1'b0, 12'd100, 2'd1,
                 32'hFFFF_FFFF, 32'h0080_0000, 32'h0000_0000);
      queue_beat(upfc_pkg::KIND_POST, 1'b0, 12'd100, 2'd1,
                 32'h0000_0001, 32'h0080_0000, 32'h0000_0000);
      queue_beat(upfc_pkg::KIND_POST, 1'b0, 12'd100, 2'd1,
                 32'hFFFF_FFFF, 32'h0080_0000, 32'h1234_5678);
      queue_beat(upfc_pkg::KIND_PRE,  1'b1, 12'd7, 2'd1,
                 32'h0001_0000, 32'h0100_0000, 32'h0100_0000);
      queue_beat(upfc_pkg::KIND_POST, 1'b1, 12'd7, 2'd1,
                 32'h0002_0000, 32'h0100_0000, 32'h0000_0000);
      queue_beat(upfc_pkg::KIND_PRE,  1'b1, 12'd7, 2'd1,
                 32'hFFFF_0000, 32'h00F0_0000, 32'h00FF_0000);
      // unused component touches no flux word
      queue_beat(upfc_pkg::KIND_PRE,  1'b0, 12'd0, upfc_pkg::COMP_UNUSED,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      queue_beat(upfc_pkg::KIND_POST, 1'b1, 12'd4095, upfc_pkg::COMP_UNUSED,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      queue_beat(upfc_pkg::KIND_PRE,  1'b0, 12'd0, 2'd0,
                 32'h0000_0000, 32'h0000_0000, 32'h0100_0000);
      queue_beat(upfc_pkg::KIND_PRE,  1'b1, 12'd2048, 2'd0,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_beat(upfc_pkg::KIND_POST, 1'b1, 12'd2048, 2'd0,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_beat(upfc_pkg::KIND_PRE,  1'b1, 12'd2048, 2'd0,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);

      // Random: mostly pre/post pairs on one flux word, the rest single loose beats
      n = 0;
      while (n < RANDOM_BEATS) begin
         if ($urandom_range(0, 99) < 65) begin
            sel      = 1'($urandom_range(0, 1));
            cell_idx = pick_cell();
            comp     = 2'($urandom_range(0, 2));
            queue_beat(upfc_pkg::KIND_PRE,  sel, cell_idx, comp,
                       pick_field(), pick_coef(), pick_coef());
            queue_beat(upfc_pkg::KIND_POST, sel, cell_idx, comp,
                       pick_field(), pick_coef(), $urandom);
            n += 2;
         end else begin
            queue_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       ($urandom_range(0, 1) != 0) ? pick_cell()
                                                   : upfc_pkg::CELL_W'($urandom),
                       2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
            n++;
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Drain: everything sent and answered, then let the pipeline settle
      while (beats_to_send.size() > 0 || req_valid || flux_answers_due.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && flux_answers_due.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
